// ----- hdl/skcp_pkg.sv -----
// Package with the types and constants shared by the serial key command parser.
`timescale 1ns / 1ps

package skcp_pkg;

  // Link byte values that make up the three messages.
  localparam logic [7:0] SYNC_A_BYTE    = 8'h55;
  localparam logic [7:0] SYNC_B_BYTE    = 8'hAA;
  localparam logic [7:0] KEEPALIVE_BYTE = 8'h00;
  localparam logic [7:0] ANNOUNCE_BYTE  = 8'h05;
  localparam logic [7:0] KEY_SHORT_BYTE = 8'h03;
  localparam logic [7:0] KEY_LONG_BYTE  = 8'h04;

  // Configuration register indexes and reset values.
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_INVALID_KEY = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PTT_KEY     = 1'b1;
  localparam logic [7:0] INVALID_KEY_RESET = 8'd19;
  localparam logic [7:0] PTT_KEY_RESET     = 8'd16;

  // Input command codes.
  localparam logic CMD_BYTE    = 1'b0;
  localparam logic CMD_CONSUME = 1'b1;

  // Parser phase, one-hot.
  typedef enum logic [8:0] {
    PH_IDLE  = 9'b0_0000_0001,
    PH_KA1   = 9'b0_0000_0010,
    PH_KA2   = 9'b0_0000_0100,
    PH_KA3   = 9'b0_0000_1000,
    PH_ANN   = 9'b0_0001_0000,
    PH_KEY1  = 9'b0_0010_0000,
    PH_KEY2  = 9'b0_0100_0000,
    PH_KEY3  = 9'b0_1000_0000,
    PH_KEY3L = 9'b1_0000_0000
  } phase_t;

  // One input transaction.
  typedef struct packed {
    logic       command;
    logic [7:0] byte_value;
  } in_item_t;

  // One result transaction.
  typedef struct packed {
    logic       connected;
    logic       key_held;
    logic [7:0] held_key_code;
  } out_item_t;

  // Current configuration handed to the parser.
  typedef struct packed {
    logic [7:0] invalid_key_code;
    logic [7:0] ptt_key_code;
  } cfg_t;

endpackage

// ----- hdl/skcp_cfg_regs.sv -----
// Configuration registers of the serial key command parser.
`timescale 1ns / 1ps

module skcp_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [skcp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                     cfg_data,
  output skcp_pkg::cfg_t                 cfg
);
  import skcp_pkg::*;

  logic [7:0] invalid_key_r;
  logic [7:0] ptt_key_r;

  // Writes are always taken.
  assign cfg_ready = 1'b1;

  // Register file update on a write transaction.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      invalid_key_r <= INVALID_KEY_RESET;
      ptt_key_r     <= PTT_KEY_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_INVALID_KEY: invalid_key_r <= cfg_data;
        CFG_PTT_KEY:     ptt_key_r     <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cfg.invalid_key_code = invalid_key_r;
  assign cfg.ptt_key_code     = ptt_key_r;

endmodule

// ----- hdl/skcp_parser.sv -----
// Message parser state machine and held-key register.
`timescale 1ns / 1ps

module skcp_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  skcp_pkg::in_item_t  item,
  input  skcp_pkg::cfg_t      cfg,
  output skcp_pkg::out_item_t result
);
  import skcp_pkg::*;

  phase_t     phase_r, phase_nxt;
  logic [7:0] held_key_r, held_key_nxt;
  logic       held_valid_r, held_valid_nxt;
  logic       conn;
  logic       key_ok;

  // A key code is taken when it is below the limit and is not push-to-talk.
  assign key_ok = (item.byte_value < cfg.invalid_key_code) &&
                  (item.byte_value != cfg.ptt_key_code);

  // Next phase, connected flag and held key for the current transaction.
  always_comb begin
    phase_nxt      = phase_r;
    held_key_nxt   = held_key_r;
    held_valid_nxt = held_valid_r;
    conn           = 1'b0;
    if (item.command == CMD_CONSUME) begin
      held_key_nxt   = 8'd0;
      held_valid_nxt = 1'b0;
    end else begin
      phase_nxt = PH_IDLE;
      unique case (phase_r)
        PH_IDLE: begin
          if (item.byte_value == SYNC_A_BYTE) begin
            phase_nxt = PH_KA1;
          end else if (item.byte_value == SYNC_B_BYTE) begin
            phase_nxt = PH_KEY1;
          end
        end
        PH_KA1: begin
          if (item.byte_value == SYNC_B_BYTE) begin
            phase_nxt = PH_KA2;
          end
        end
        PH_KA2: begin
          if (item.byte_value == KEEPALIVE_BYTE) begin
            phase_nxt = PH_KA3;
          end else if (item.byte_value == ANNOUNCE_BYTE) begin
            phase_nxt = PH_ANN;
          end
        end
        PH_KA3: begin
          conn = (item.byte_value == KEEPALIVE_BYTE);
        end
        PH_ANN: begin
          conn = 1'b1;
        end
        PH_KEY1: begin
          if (item.byte_value == SYNC_A_BYTE) begin
            phase_nxt = PH_KEY2;
          end
        end
        PH_KEY2: begin
          if (item.byte_value == KEY_SHORT_BYTE) begin
            phase_nxt = PH_KEY3;
          end else if (item.byte_value == KEY_LONG_BYTE) begin
            phase_nxt = PH_KEY3L;
          end
        end
        PH_KEY3, PH_KEY3L: begin
          conn = 1'b1;
          if (key_ok) begin
            held_key_nxt   = item.byte_value;
            held_valid_nxt = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // State update, only when a transaction is processed.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      held_key_r   <= 8'd0;
      held_valid_r <= 1'b0;
    end else if (step) begin
      phase_r      <= phase_nxt;
      held_key_r   <= held_key_nxt;
      held_valid_r <= held_valid_nxt;
    end
  end

  // Result reflects the state after this transaction.
  assign result.connected     = conn;
  assign result.key_held      = held_valid_nxt;
  assign result.held_key_code = held_valid_nxt ? held_key_nxt : 8'd0;

  // A consume command always leaves no key held.
  a_consume_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (step && item.command == CMD_CONSUME) |=> !held_valid_r)
    else $error("held key survived a consume command");

  // The phase only moves when a byte transaction is processed.
  a_phase_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(step && item.command == CMD_BYTE) |=> $stable(phase_r))
    else $error("parser phase moved without a byte");

endmodule

// ----- hdl/serial_key_command_parser.sv -----
// Serial key command parser: recognises keepalive, announce and key messages byte by byte.
//
// Input channel: in_valid / in_stall / in_data carry one transaction per cycle when
// not stalled, either a received link byte or a consume command that clears the held key.
// Result channel: out_valid / out_stall / out_data return exactly one result
// per input transaction, in order: connected, key_held and held_key_code.
// Configuration: cfg_valid / cfg_ready / cfg_index / cfg_data write the
// invalid-key limit (index 0) and the push-to-talk code (index 1); writes
// are always taken and belong to idle periods.
// Data path: a transaction accepted by the input channel is registered in the
// input stage; the parser step then writes its result into the output register.
// Throughput: one transaction per cycle while the receiver does not stall, set by
// the combinational parser step between the input register and the output register.
// Reset (rst_n low, synchronous): parser back to idle, no key held, both
// configuration registers to their defaults, both stages empty.
// When the receiver stalls, the output register holds its result; the input
// stage still accepts one more transaction and then stalls the sender.
`timescale 1ns / 1ps

module serial_key_command_parser (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  skcp_pkg::in_item_t             in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output skcp_pkg::out_item_t            out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [skcp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                     cfg_data
);
  import skcp_pkg::*;

  cfg_t      cfg;
  logic      s1_valid_r, s1_valid_nxt;
  in_item_t  s1_item_r;
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_item_r;
  out_item_t step_result;
  logic      advance;
  logic      in_accept;

  skcp_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  skcp_parser u_parser (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (advance),
    .item   (s1_item_r),
    .cfg    (cfg),
    .result (step_result)
  );

  // Pipeline control: the input stage moves on when the output register is free or drained.
  assign advance   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !advance;
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt  = in_accept ? 1'b1 : (advance ? 1'b0 : s1_valid_r);
    out_valid_nxt = advance ? 1'b1 : (out_valid_r && out_stall);
  end

  // Valid flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_item_r <= in_data;
    end
    if (advance) begin
      out_item_r <= step_result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  // No held key means the reported code is zero.
  a_code_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_item_r.key_held) |-> (out_item_r.held_key_code == 8'd0))
    else $error("held key code not zero while no key is held");

  // A consume command produces a result with no connection and no key held.
  a_consume_result: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && s1_item_r.command == CMD_CONSUME) |=>
      (out_valid_r && !out_item_r.connected && !out_item_r.key_held))
    else $error("consume command produced a wrong result");

  // A waiting input transaction is not lost while the output is blocked.
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !advance) |=> (s1_valid_r && $stable(s1_item_r)))
    else $error("input stage dropped or changed a waiting transaction");

endmodule
